FILE: rtl/hhsa_pkg.sv
// ---------------------------------------------------------------------------
// Heading hold setpoint advance: shared package
// Constants, register indexes and the queue entry type used by the front end,
// the item queue, the back end and the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hhsa_pkg;

	// Longest tick that is still integrated, in microseconds.
	localparam logic [19:0] MAX_DT_US  = 20'd500000;
	// Deadband ceiling, 0.9 in Q0.16 rounded down.
	localparam logic [15:0] DB_MAX_Q16 = 16'd58982;
	// One full stick in Q0.16.
	localparam logic [16:0] FULL_Q16   = 17'h10000;
	// Microseconds per second.
	localparam logic [19:0] US_PER_S   = 20'd1000000;

	// The rounded quotient always fits in this many bits, since the stick
	// excess never exceeds the rescale factor and slew times dt stays below
	// 2^24 seconds worth of angle units.
	localparam int unsigned DIV_STEPS = 24;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	// Depth of the queue between front and back end.
	localparam int unsigned QUEUE_DEPTH = 2;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_DEADBAND = 2'd0,
		REG_SLEW     = 2'd1,
		REG_LEAD     = 2'd2
	} reg_index_t;

	// One classified tick, as handed from the front end to the back end.
	typedef struct packed {
		logic [15:0] live;    // live heading
		logic        resync;  // seed held heading from live heading
		logic        integ;   // tick is integrated
		logic        neg;     // stick points negative
		logic [16:0] excess;  // stick magnitude above the deadband, Q0.16
		logic [16:0] factor;  // full scale minus the deadband, Q0.16
		logic [19:0] dt;      // elapsed time in microseconds
	} hhsa_item_t;

endpackage

`default_nettype wire

FILE: rtl/hhsa_front.sv
// ---------------------------------------------------------------------------
// Heading hold setpoint advance: front end
// Accepts input transactions, unpacks them and classifies the stick against
// the clamped deadband, then pushes one entry into the item queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hhsa_front
	import hhsa_pkg::*;
(
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// Fields from bit 0 up: live_heading[15:0], turn_command[31:16],
	// elapsed_us[51:32], zero padding[55:52].
	input  wire logic [55:0] s_tdata,
	// Fields from bit 0 up: resync.
	input  wire logic        s_tuser,
	input  wire logic [15:0] deadband_level,
	input  wire logic        q_full,
	output logic             q_push,
	output hhsa_item_t       q_item
);

	logic [15:0] live;
	logic [15:0] cmd;
	logic [19:0] dt;
	logic [15:0] mag15;
	logic [16:0] mag;
	logic [15:0] db;
	logic        dt_ok;

	// Unpack the transaction.
	assign live = s_tdata[15:0];
	assign cmd  = s_tdata[31:16];
	assign dt   = s_tdata[51:32];

	// Stick magnitude in Q0.16; the most negative code gives exactly one.
	always_comb begin
		if (cmd[15]) begin
			mag15 = 16'd0 - cmd;
		end else begin
			mag15 = cmd;
		end
		mag = {mag15, 1'b0};
	end

	// Deadband clamp and time window check.
	assign db    = (deadband_level > DB_MAX_Q16) ? DB_MAX_Q16 : deadband_level;
	assign dt_ok = (dt != 20'd0) && (dt <= MAX_DT_US);

	// Build the queue entry.
	always_comb begin
		q_item.live   = live;
		q_item.resync = s_tuser;
		q_item.integ  = dt_ok && (mag > {1'b0, db});
		q_item.neg    = cmd[15];
		q_item.excess = mag - {1'b0, db};
		q_item.factor = FULL_Q16 - {1'b0, db};
		q_item.dt     = dt;
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

endmodule

`default_nettype wire

FILE: rtl/hhsa_queue.sv
// ---------------------------------------------------------------------------
// Heading hold setpoint advance: item queue
// A short first-in first-out queue of classified ticks between the front end
// and the back end, so that each side can stall on its own.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hhsa_queue
	import hhsa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire hhsa_item_t push_item,
	output logic            full,
	input  wire logic       pop,
	output logic            head_valid,
	output hhsa_item_t      head_item
);

	localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned COUNT_W = $clog2(QUEUE_DEPTH + 1);

	hhsa_item_t         entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [COUNT_W-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Entry storage; payload needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				if (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + PTR_W'(1);
				end
			end
			if (do_pop) begin
				if (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + PTR_W'(1);
				end
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + COUNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - COUNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	// The fill count never passes the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");

	// A push into an empty queue makes the head valid next cycle.
	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !head_valid) |=> head_valid)
		else $error("pushed entry not visible at head");
`endif

endmodule

`default_nettype wire

FILE: rtl/hhsa_back.sv
// ---------------------------------------------------------------------------
// Heading hold setpoint advance: back end
// Pops classified ticks, forms the rate increment with three registered
// multiplies and a restoring divider, advances the held heading, applies the
// lead clamp and presents the result in an output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hhsa_back
	import hhsa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire hhsa_item_t  q_item,
	output logic             q_pop,
	input  wire logic [23:0] slew_rate,
	input  wire logic [15:0] lead_limit,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// Fields from bit 0 up: held_heading_out[15:0].
	output logic [15:0]      m_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_ROUND,
		ST_DIV,
		ST_APPLY,
		ST_CLAMP,
		ST_WAIT
	} state_t;

	state_t           state_q;
	hhsa_item_t       item_q;
	logic [40:0]      p1_q;
	logic [35:0]      den_q;
	logic [60:0]      rem_q;
	logic [60:0]      dsh_q;
	logic [15:0]      quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic [15:0]      hh_q;
	logic             m_tvalid_q;
	logic [15:0]      m_tdata_q;

	logic [40:0]      prod1;
	logic [35:0]      den_full;
	logic [60:0]      prod2;
	logic [60:0]      rem_sub;
	logic             rem_ge;
	logic [15:0]      base;
	logic [15:0]      stepped;
	logic [15:0]      diff;
	logic signed [17:0] lead;
	logic signed [17:0] lim;
	logic signed [17:0] lead_c;

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	// Multiplier products, each registered before use.
	assign prod1    = {24'd0, item_q.excess} * {17'd0, slew_rate};
	assign den_full = {19'd0, item_q.factor} * {16'd0, US_PER_S};
	assign prod2    = {20'd0, p1_q} * {41'd0, item_q.dt};

	// One restoring division step.
	assign rem_ge  = (rem_q >= dsh_q);
	assign rem_sub = rem_q - dsh_q;

	// Heading update with the increment.
	always_comb begin
		base = item_q.resync ? item_q.live : hh_q;
		if (!item_q.integ) begin
			stepped = base;
		end else if (item_q.neg) begin
			stepped = base - quo_q;
		end else begin
			stepped = base + quo_q;
		end
	end

	// Lead over the live heading, clamped to the limit.
	always_comb begin
		diff = hh_q - item_q.live;
		lead = {{2{diff[15]}}, diff};
		lim  = {2'b00, lead_limit};
		if (lead > lim) begin
			lead_c = lim;
		end else if (lead < -lim) begin
			lead_c = -lim;
		end else begin
			lead_c = lead;
		end
	end

	// Sequencer and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			hh_q       <= 16'd0;
			m_tvalid_q <= 1'b0;
			cnt_q      <= '0;
		end else begin
			// The wait state reloads the output register itself.
			if (m_tvalid_q && m_tready && state_q != ST_WAIT) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						item_q <= q_item;
						if (q_item.integ) begin
							state_q <= ST_MUL1;
						end else begin
							state_q <= ST_APPLY;
						end
					end
				end
				ST_MUL1: begin
					p1_q    <= prod1;
					den_q   <= den_full;
					state_q <= ST_MUL2;
				end
				ST_MUL2: begin
					rem_q   <= prod2;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					// Round half up, then align the divisor to the top quotient bit.
					rem_q   <= rem_q + {25'd0, 1'b0, den_q[35:1]};
					dsh_q   <= {25'd0, den_q} << (DIV_STEPS - 1);
					quo_q   <= 16'd0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (rem_ge) begin
						rem_q <= rem_sub;
					end
					quo_q <= {quo_q[14:0], rem_ge};
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					hh_q    <= stepped;
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (lead_limit != 16'd0) begin
						hh_q <= item_q.live + lead_c[15:0];
					end
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= hh_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	// A new result appears only out of the wait state.
	a_result_from_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !$past(m_tvalid_q)) |-> ($past(state_q) == ST_WAIT))
		else $error("result raised outside the wait state");

	// After the last division step the remainder is below the divisor.
	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_APPLY && item_q.integ) |-> (rem_q < {25'd0, den_q}))
		else $error("division remainder not below divisor");

	// The queue is popped only by an idle sequencer, which then leaves idle.
	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> (state_q == ST_MUL1 || state_q == ST_APPLY))
		else $error("pop did not start an item");
`endif

endmodule

`default_nettype wire

FILE: rtl/heading_hold_setpoint_advance.sv
// ---------------------------------------------------------------------------
// Heading hold setpoint advance
// Integrates a shaped stick turn command into a held heading setpoint, with
// a deadband, a rescale to full range and an optional lead clamp.
// ---------------------------------------------------------------------------
// Usage:
//   The input stream carries one control tick per transaction: live heading,
//   stick value and elapsed time in s_tdata, the resync flag in s_tuser.
//   Each tick yields exactly one transaction on the output stream carrying the
//   new held heading. Registers are written through cfg_we, cfg_index and
//   cfg_data only while the block is idle, which the user must ensure; the
//   block itself does not enforce it. Index 0 is the deadband, 1 the slew rate,
//   2 the lead limit, other indexes are ignored. The back end sequencer
//   works on one tick at a time: it takes the next tick from the queue only
//   after the current one has passed its multiply, round, 24-step restoring
//   divide, apply, clamp and wait states; a tick that is not integrated goes
//   straight to apply. A two-entry queue lets the input side keep accepting
//   ticks while the back end is busy.
//   Reset clears the held heading to zero and loads the register defaults.
//   When the receiver stalls, the result holds in the output register, the
//   next tick is computed and waits behind it, and the input side stops once
//   the queue is full.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module heading_hold_setpoint_advance
	import hhsa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// Fields from bit 0 up: live_heading[15:0], turn_command[31:16],
	// elapsed_us[51:32], zero padding[55:52].
	input  wire logic [55:0] s_tdata,
	// Fields from bit 0 up: resync.
	input  wire logic        s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// Fields from bit 0 up: held_heading_out[15:0].
	output logic [15:0]      m_tdata,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	logic [15:0] deadband_q;
	logic [23:0] slew_q;
	logic [15:0] lead_q;

	logic        q_full;
	logic        q_push;
	hhsa_item_t  q_in;
	logic        q_valid;
	hhsa_item_t  q_head;
	logic        q_pop;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= 16'd3277;
			slew_q     <= 24'd16384;
			lead_q     <= 16'd0;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_DEADBAND: deadband_q <= cfg_data[15:0];
				REG_SLEW:     slew_q     <= cfg_data;
				REG_LEAD:     lead_q     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	hhsa_front u_front (
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.deadband_level (deadband_q),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_item         (q_in)
	);

	hhsa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_head)
	);

	hhsa_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_item     (q_head),
		.q_pop      (q_pop),
		.slew_rate  (slew_q),
		.lead_limit (lead_q),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

`default_nettype wire

FILE: tb/sv/heading_hold_setpoint_advance_test.sv
// ---------------------------------------------------------------------------
// Heading hold setpoint advance: self-checking testbench
// Feeds control ticks into the block over the input stream and predicts each
// new held heading from its own copy of the registers and the setpoint.
// A short directed run covers the field extremes, the deadband and lead
// clamp corners and the wrap of large increments. Random phases follow,
// each with fresh register settings and one of four mixes of sender gaps
// and receiver stalls, taken in turn.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module heading_hold_setpoint_advance_test;
	import hhsa_pkg::*;

	localparam int unsigned STALL_LIMIT     = 4000;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned TICKS_PER_PHASE = 137;
	localparam int unsigned REPORT_LIMIT    = 10;

	// Tracks the held heading setpoint and the headings still owed by the block.
	class heading_tracker;
		logic [15:0] deadband   = 16'd3277;
		logic [23:0] slew       = 24'd16384;
		logic [15:0] lead_limit = 16'd0;
		logic [15:0] held       = 16'd0;
		logic [15:0] expected_headings[$];
		int unsigned mismatches = 0;
		int unsigned results    = 0;

		function void set_register(reg_index_t idx, logic [23:0] value);
			case (idx)
				REG_DEADBAND: deadband = value[15:0];
				REG_SLEW: slew = value;
				REG_LEAD: lead_limit = value[15:0];
				default: ;
			endcase
		endfunction

		// Advance the setpoint by one accepted tick and queue the new heading.
		function void note_tick(logic [15:0] live, logic [15:0] cmd, logic [19:0] dt,
				logic resync);
			logic neg;
			logic [16:0] mag;
			longint unsigned m, d, num, den, delta;
			logic [15:0] diff;
			int lead, lim;

			if (resync) begin
				held = live;
			end

			// Stick shaping and integration over the elapsed time.
			if (dt >= 20'd1 && dt <= MAX_DT_US) begin
				neg = cmd[15];
				mag = neg ? FULL_Q16 - {1'b0, cmd} : {1'b0, cmd};
				m = 64'(mag);
				m = m * 2;
				d = 64'((deadband > DB_MAX_Q16) ? DB_MAX_Q16 : deadband);
				if (m > d) begin
					num = (m - d) * 64'(slew) * 64'(dt);
					den = (64'(FULL_Q16) - d) * 64'(US_PER_S);
					delta = (num + den / 2) / den;
					held = neg ? held - delta[15:0] : held + delta[15:0];
				end
			end

			// Lead clamp against the live heading.
			if (lead_limit != 16'd0) begin
				diff = held - live;
				lead = int'($signed(diff));
				lim = int'(lead_limit);
				if (lead > lim) begin
					lead = lim;
				end
				if (lead < -lim) begin
					lead = -lim;
				end
				held = live + lead[15:0];
			end

			expected_headings.push_back(held);
		endfunction

		function void note_mismatch(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("%s", msg);
			end
		endfunction

		// Compare one output transaction with the oldest owed heading.
		function void check_heading(logic [15:0] got);
			logic [15:0] want;

			results++;
			if (expected_headings.size() == 0) begin
				note_mismatch($sformatf("result %0d: heading %0d with no tick pending",
					results, got));
			end else begin
				want = expected_headings.pop_front();
				if (got !== want) begin
					note_mismatch($sformatf("result %0d: held heading expected %0d, got %0d",
						results, want, got));
				end
			end
		endfunction

		function int unsigned pending();
			return expected_headings.size();
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [55:0] s_tdata   = '0;
	logic        s_tuser   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_we    = 1'b0;
	reg_index_t  cfg_index = REG_DEADBAND;
	logic [23:0] cfg_data  = '0;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned quiet_cycles   = 0;

	heading_tracker tracker = new();

	heading_hold_setpoint_advance DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Receiver backpressure.
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Transaction monitor and watchdog on cycles with no progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				tracker.note_tick(s_tdata[15:0], s_tdata[31:16], s_tdata[51:32], s_tuser);
			end
			if (m_tvalid && m_tready) begin
				tracker.check_heading(m_tdata);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Present one tick, with random gaps ahead of it, and wait until it is taken.
	task automatic send_tick(input logic [15:0] live, input logic [15:0] cmd,
			input logic [19:0] dt, input logic resync);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, dt, cmd, live};
		s_tuser  <= resync;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	// Hold off the sender until every owed heading has come back.
	task automatic wait_drain();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (tracker.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// Write all three registers; only called while the block is idle.
	task automatic write_settings(input logic [15:0] db, input logic [23:0] slew,
			input logic [15:0] lead);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEADBAND;
		cfg_data  <= {8'd0, db};
		@(posedge clk);
		tracker.set_register(REG_DEADBAND, {8'd0, db});
		cfg_index <= REG_SLEW;
		cfg_data  <= slew;
		@(posedge clk);
		tracker.set_register(REG_SLEW, slew);
		cfg_index <= REG_LEAD;
		cfg_data  <= {8'd0, lead};
		@(posedge clk);
		tracker.set_register(REG_LEAD, {8'd0, lead});
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] live, cmd, db, lead, d_eff;
		logic [23:0] slew;
		logic [19:0] dt;
		logic resync;
		int unsigned pause_at;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: seeding, full stick both ways, the time window edges
		// and the deadband boundary.
		send_tick(16'd100, 16'd0, 20'd1000, 1'b1);
		send_tick(16'd100, 16'd32767, 20'd500000, 1'b0);
		send_tick(16'd100, 16'h8000, 20'd500000, 1'b0);
		send_tick(16'd100, 16'd32767, 20'd500001, 1'b0);
		send_tick(16'd100, 16'd32767, 20'd0, 1'b0);
		send_tick(16'd100, 16'd1, 20'd1, 1'b0);
		send_tick(16'hFFFF, 16'h8000, 20'hFFFFF, 1'b1);
		send_tick(16'd5000, 16'd1600, 20'd250000, 1'b0);
		send_tick(16'd5000, 16'd1639, 20'd500000, 1'b0);
		wait_drain();

		// Deadband above the ceiling and the fastest slew: increments wrap.
		write_settings(16'hFFFF, 24'hFFFFFF, 16'd0);
		send_tick(16'd0, 16'd32767, 20'd500000, 1'b1);
		send_tick(16'd0, 16'h8000, 20'd500000, 1'b0);
		send_tick(16'd0, 16'd29491, 20'd500000, 1'b0);
		send_tick(16'd0, 16'd29492, 20'd123457, 1'b0);
		wait_drain();

		// No deadband, widest lead limit, including a lead of exactly half a turn.
		write_settings(16'd0, 24'hFFFFFF, 16'h8000);
		send_tick(16'd0, 16'd0, 20'd0, 1'b1);
		send_tick(16'h8000, 16'd0, 20'd0, 1'b0);
		send_tick(16'd1234, 16'd32767, 20'd500000, 1'b0);
		wait_drain();

		// Tightest lead limit at the deadband ceiling.
		write_settings(16'd58982, 24'd1000, 16'd1);
		send_tick(16'd40000, 16'd32767, 20'd500000, 1'b1);
		send_tick(16'd40000, 16'h8000, 20'd500000, 1'b0);
		send_tick(16'd0, 16'd0, 20'd0, 1'b0);
		wait_drain();

		// Zero slew rate.
		write_settings(16'd58983, 24'd0, 16'd100);
		send_tick(16'd7, 16'd32767, 20'd500000, 1'b0);
		send_tick(16'hFFFF, 16'hFFFF, 20'd1, 1'b0);
		wait_drain();

		// Random phases, each with new settings and one of four idling mixes in turn.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 23; recv_stall_pct = 23; end
			endcase

			case ($urandom_range(5))
				0: db = 16'd0;
				1: db = 16'd3277;
				2: db = 16'd58982;
				3: db = 16'd58983;
				4: db = 16'hFFFF;
				default: db = 16'($urandom);
			endcase
			case ($urandom_range(5))
				0: slew = 24'd0;
				1: slew = 24'd1;
				2: slew = 24'd16384;
				3: slew = 24'hFFFFFF;
				4: slew = 24'($urandom);
				default: slew = 24'($urandom_range(200000));
			endcase
			case ($urandom_range(5))
				0: lead = 16'd0;
				1: lead = 16'd1;
				2: lead = 16'd32767;
				3: lead = 16'h8000;
				4: lead = 16'($urandom_range(32768));
				default: lead = 16'($urandom_range(2000));
			endcase
			write_settings(db, slew, lead);
			d_eff = (db > DB_MAX_Q16) ? DB_MAX_Q16 : db;
			pause_at = $urandom_range(TICKS_PER_PHASE - 1);

			for (int i = 0; i < TICKS_PER_PHASE; i++) begin
				if (i == pause_at) begin
					wait_drain();
				end

				// Live heading: mostly anywhere, sometimes close to the setpoint.
				if ($urandom_range(9) < 3) begin
					live = 16'(tracker.held + $urandom_range(400) - 200);
				end else begin
					live = 16'($urandom);
				end

				// Stick: uniform, full-scale corners, or right at the deadband edge.
				case ($urandom_range(9))
					0: cmd = 16'h8000;
					1: cmd = 16'd32767;
					2: cmd = ($urandom_range(1) == 0) ? 16'd0 : 16'hFFFF;
					3, 4: begin
						cmd = 16'((d_eff >> 1) + $urandom_range(4) - 2);
						if ($urandom_range(1) == 1) begin
							cmd = -cmd;
						end
					end
					default: cmd = 16'($urandom);
				endcase

				// Elapsed time: mostly inside the window, with its edges and beyond.
				case ($urandom_range(9))
					0: dt = 20'd0;
					1: dt = 20'($urandom);
					2: begin
						case ($urandom_range(2))
							0: dt = 20'd1;
							1: dt = MAX_DT_US;
							default: dt = MAX_DT_US + 20'd1;
						endcase
					end
					3: dt = 20'($urandom_range(1000));
					default: dt = 20'($urandom_range(500000, 1));
				endcase

				resync = ($urandom_range(9) == 0);
				send_tick(live, cmd, dt, resync);
			end
			wait_drain();
		end

		repeat (40) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
